[rtl/core/learned_level_switch_decoder_defines.svh]
// Assertion macros for the learned level switch decoder.
// Define NO_ASSERTIONS to compile them out.
`ifndef LEARNED_LEVEL_SWITCH_DECODER_DEFINES_SVH
`define LEARNED_LEVEL_SWITCH_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lls check failed");
`define LLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lls check failed");
`else
`define LLS_ASSERT_SAME(lbl, ante, cons)
`define LLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/lls_pkg.sv]
`default_nettype none

package lls_pkg;

  localparam int MAX_LEVELS  = 8;
  localparam int SAMPLE_BITS = 10;
  localparam int IDX_BITS    = $clog2(MAX_LEVELS);
  localparam int CNT_BITS    = $clog2(MAX_LEVELS + 1);
  localparam int DIST_BITS   = 16;

  localparam int KIND_BITS      = 2;
  localparam int SAMPLE_IN_BITS = 10;
  localparam int ENTRY_BITS     = 3;
  localparam int POS_BITS       = 3;
  localparam int LCOUNT_BITS    = 4;

  localparam logic [DIST_BITS-1:0] DIST_START = 16'hFFFF;

  localparam logic [KIND_BITS-1:0] KIND_CLASSIFY = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_LEARN    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE   = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0]      kind;
    logic [SAMPLE_IN_BITS-1:0] sample;
    logic [ENTRY_BITS-1:0]     entry_index;
  } in_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    position;
    logic [LCOUNT_BITS-1:0] level_count;
  } out_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic [DIST_BITS-1:0] best;
    logic [IDX_BITS-1:0]  pick;
  } tok_t;

  // broadcast to every cell
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic [SAMPLE_BITS-1:0] smp;
    logic [ENTRY_BITS-1:0]  idx;
    logic [CNT_BITS-1:0]    cnt;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/core/learned_level_switch_decoder.sv]
`default_nettype none
`include "learned_level_switch_decoder_defines.svh"

// Learned level switch decoder. Keeps up to MAX_LEVELS learned levels in
// descending order in a row of cells, one level per cell. A learn or remove
// item updates all cells together in the edit state. A classify item sends
// a search token down the row, one cell per cycle. Every item keeps the
// input stalled until its result is loaded into the output register, and
// a result waiting there with the output stalled keeps it stalled longer.
// Level storage has no reset; the level count resets to zero.
module learned_level_switch_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  lls_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_stall,
  output lls_pkg::out_t  result
);
  import lls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EDIT   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_WAIT   = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [KIND_BITS-1:0]   op;
  logic [SAMPLE_BITS-1:0] smp;
  logic [ENTRY_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]    count, count_next;
  logic                   launch;
  logic [IDX_BITS-1:0]    pos;
  logic                   take;
  logic                   load;
  logic                   room;
  logic                   hit;
  ctl_t                   ctl;
  tok_t                   tok [MAX_LEVELS+1];
  logic [SAMPLE_BITS-1:0] lvl [MAX_LEVELS];
  logic                   ge  [MAX_LEVELS];

  assign item_stall = (state != S_IDLE);
  assign take       = item_valid && !item_stall;
  assign load       = (state == S_WAIT) && (!result_valid || !result_stall);
  assign room       = int'(count) < MAX_LEVELS;
  assign hit        = int'(idx) < int'(count);

  assign ctl = '{ins: (state == S_EDIT) && (op == KIND_LEARN) && room,
                 rem: (state == S_EDIT) && (op == KIND_REMOVE) && hit,
                 smp: smp,
                 idx: idx,
                 cnt: count};

  assign tok[0] = '{vld: launch, best: DIST_START, pick: '0};

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_l;
    logic                   left_g;
    logic [SAMPLE_BITS-1:0] right_l;

    if (i == 0) begin : g_first
      assign left_l = smp;
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_l = lvl[i-1];
      assign left_g = ge[i-1];
    end

    if (i == MAX_LEVELS - 1) begin : g_last
      assign right_l = lvl[i];
    end else begin : g_inner
      assign right_l = lvl[i+1];
    end

    lls_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .slot      (IDX_BITS'(i)),
      .ctl       (ctl),
      .tok_in    (tok[i]),
      .left_lvl  (left_l),
      .left_ge   (left_g),
      .right_lvl (right_l),
      .lvl       (lvl[i]),
      .ge        (ge[i]),
      .tok_out   (tok[i+1])
    );
  end

  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          state_next = (item.kind == KIND_CLASSIFY) ? S_SEARCH : S_EDIT;
        end
      end
      S_EDIT: begin
        if (ctl.ins) begin
          count_next = count + CNT_BITS'(1);
        end else if (ctl.rem) begin
          count_next = count - CNT_BITS'(1);
        end
        state_next = S_WAIT;
      end
      S_SEARCH: begin
        if (tok[MAX_LEVELS].vld) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      launch       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      launch <= take && (item.kind == KIND_CLASSIFY);
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op  <= item.kind;
      smp <= SAMPLE_BITS'(item.sample);
      idx <= item.entry_index;
    end
    if (state == S_EDIT) begin
      pos <= '0;
    end else if ((state == S_SEARCH) && tok[MAX_LEVELS].vld) begin
      // pick counts from the highest level; report from the lowest
      pos <= (count == '0) ? '0 :
             IDX_BITS'(count - CNT_BITS'(1) - CNT_BITS'(tok[MAX_LEVELS].pick));
    end
    if (load) begin
      result <= '{position: POS_BITS'(pos), level_count: LCOUNT_BITS'(count)};
    end
  end

  `LLS_ASSERT_SAME(a_count_max, 1'b1, int'(count) <= MAX_LEVELS)
  `LLS_ASSERT_SAME(a_count_edit, count != $past(count), $past(state == S_EDIT))
  `LLS_ASSERT_SAME(a_tok_search, tok[MAX_LEVELS].vld || launch, state == S_SEARCH)
  `LLS_ASSERT_NEXT(a_take_busy, take, state != S_IDLE)

endmodule

`default_nettype wire

[rtl/core/lls_cell.sv]
`default_nettype none

module lls_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lls_pkg::IDX_BITS-1:0]    slot,
  input  lls_pkg::ctl_t                   ctl,
  input  lls_pkg::tok_t                   tok_in,
  input  logic [lls_pkg::SAMPLE_BITS-1:0] left_lvl,
  input  logic                            left_ge,
  input  logic [lls_pkg::SAMPLE_BITS-1:0] right_lvl,
  output logic [lls_pkg::SAMPLE_BITS-1:0] lvl,
  output logic                            ge,
  output lls_pkg::tok_t                   tok_out
);
  import lls_pkg::*;

  logic                   live;
  logic [SAMPLE_BITS-1:0] gap;
  logic                   closer;
  logic                   tok_vld;
  logic [DIST_BITS-1:0]   tok_best;
  logic [IDX_BITS-1:0]    tok_pick;

  assign live   = int'(slot) < int'(ctl.cnt);
  assign ge     = live && (lvl >= ctl.smp);
  assign gap    = (ctl.smp > lvl) ? (ctl.smp - lvl) : (lvl - ctl.smp);
  assign closer = live && (DIST_BITS'(gap) < tok_in.best);

  assign tok_out = '{vld: tok_vld, best: tok_best, pick: tok_pick};

  // insert opens a gap below the last entry >= sample; remove pulls from the right
  always_ff @(posedge clk) begin
    if (ctl.ins && !ge) begin
      lvl <= left_ge ? ctl.smp : left_lvl;
    end else if (ctl.rem && (int'(slot) >= int'(ctl.idx))) begin
      lvl <= right_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_vld <= 1'b0;
    end else begin
      tok_vld <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (closer) begin
      tok_best <= DIST_BITS'(gap);
      tok_pick <= slot;
    end else begin
      tok_best <= tok_in.best;
      tok_pick <= tok_in.pick;
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lls_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int IN_BITS      = $bits(in_t);
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_LEN    = 170;
  localparam int HOLD_LEN     = 300;
  localparam int WATCHDOG_MAX = 5000;
  localparam int TAIL_CYCLES  = 40;

  typedef enum int {
    PH_DIRECT,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } tb_phase_e;

  typedef struct {
    in_t  stim;
    bit   known;
    out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t  item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  learned_level_switch_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  // shadow copy of the level table, descending
  logic [SAMPLE_BITS-1:0] lvl_tab [MAX_LEVELS];
  int        lvl_cnt = 0;
  out_t      result_q [$];
  plan_row_t plan [$];
  int        err_cnt = 0;
  int        quiet_cycles = 0;
  int        hold_cycles = 0;
  tb_phase_e phase = PH_DIRECT;
  out_t      got_want;

  function automatic out_t decode_item(in_t it);
    out_t r;
    int   best, pick, d, i, s;
    r = '0;
    s = int'(it.sample);
    case (it.kind)
      KIND_CLASSIFY: begin
        if (lvl_cnt > 0) begin
          best = int'(DIST_START);
          pick = 0;
          for (i = 0; i < lvl_cnt; i++) begin
            d = (s > int'(lvl_tab[i])) ? s - int'(lvl_tab[i]) : int'(lvl_tab[i]) - s;
            if (d < best) begin
              best = d;
              pick = i;
            end
          end
          r.position = POS_BITS'(lvl_cnt - 1 - pick);
        end
      end
      KIND_LEARN: begin
        if (lvl_cnt < MAX_LEVELS) begin
          i = lvl_cnt;
          while (i > 0 && lvl_tab[i-1] < it.sample) begin
            lvl_tab[i] = lvl_tab[i-1];
            i--;
          end
          lvl_tab[i] = it.sample;
          lvl_cnt++;
        end
      end
      KIND_REMOVE: begin
        if (int'(it.entry_index) < lvl_cnt) begin
          for (i = int'(it.entry_index); i + 1 < lvl_cnt; i++) lvl_tab[i] = lvl_tab[i+1];
          lvl_cnt--;
        end
      end
      default: ;
    endcase
    r.level_count = LCOUNT_BITS'(lvl_cnt);
    return r;
  endfunction

  function automatic int send_idle_pct();
    case (phase)
      PH_SEND_IDLE:      return 58;
      PH_BOTH, PH_DIRECT: return 22;
      default:           return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (phase)
      PH_RECV_STALL:                  return 58;
      PH_BOTH, PH_DIRECT, PH_PRESSURE: return 22;
      default:                        return 0;
    endcase
  endfunction

  function automatic in_t make_item();
    in_t it;
    int  r, j, s;
    it.kind        = KIND_BITS'($urandom);
    it.sample      = SAMPLE_IN_BITS'($urandom);
    it.entry_index = ENTRY_BITS'($urandom);
    r = $urandom_range(99);
    if (r < 40) begin
      it.kind = KIND_CLASSIFY;
      if (lvl_cnt > 0 && $urandom_range(2) == 0) begin
        j = $urandom_range(lvl_cnt - 1);
        s = int'(lvl_tab[j]) + int'($urandom_range(6)) - 3;
        if (s < 0) s = 0;
        if (s > 1023) s = 1023;
        it.sample = SAMPLE_IN_BITS'(s);
      end else if (lvl_cnt > 1 && $urandom_range(2) == 0) begin
        // midpoint between neighbors: tie case when the gap is even
        j = $urandom_range(lvl_cnt - 2);
        s = int'(lvl_tab[j]) + int'(lvl_tab[j+1]);
        it.sample = SAMPLE_IN_BITS'(s / 2);
      end
    end else if (r < 70) begin
      it.kind = KIND_LEARN;
      if (lvl_cnt > 0 && $urandom_range(4) == 0)
        it.sample = lvl_tab[$urandom_range(lvl_cnt - 1)];
    end else if (r < 95) begin
      it.kind = KIND_REMOVE;
      if (lvl_cnt > 0 && $urandom_range(4) != 0)
        it.entry_index = ENTRY_BITS'($urandom_range(lvl_cnt - 1));
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  task automatic add_row(logic [KIND_BITS-1:0] k, int smp, int idx, bit known, int pos,
                         int cnt);
    plan_row_t row;
    row.stim.kind         = k;
    row.stim.sample       = SAMPLE_IN_BITS'(smp);
    row.stim.entry_index  = ENTRY_BITS'(idx);
    row.known             = known;
    row.want.position     = POS_BITS'(pos);
    row.want.level_count  = LCOUNT_BITS'(cnt);
    plan.push_back(row);
  endtask

  task automatic send_item(in_t it, bit known, out_t want);
    out_t pred;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    pred = decode_item(it);
    result_q.push_back(known ? want : pred);
    if ($urandom_range(99) < send_idle_pct()) begin
      item_valid <= 1'b0;
      item       <= in_t'(IN_BITS'($urandom));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct());
    end
  endtask

  // receiver: one long hold at the start of the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (phase == PH_PRESSURE && hold_cycles < HOLD_LEN) begin
      result_stall <= 1'b1;
      hold_cycles  <= hold_cycles + 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (result_q.size() == 0) begin
        $error("result transfer with nothing expected: position %0d level_count %0d",
               result.position, result.level_count);
        err_cnt++;
      end else begin
        got_want = result_q.pop_front();
        if (result.position !== got_want.position) begin
          $error("position: expected %0d, actual %0d", got_want.position, result.position);
          err_cnt++;
        end
        if (result.level_count !== got_want.level_count) begin
          $error("level_count: expected %0d, actual %0d", got_want.level_count,
                 result.level_count);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("FAIL learned_level_switch_decoder");
      $finish;
    end
  end

  initial begin
    int n;
    add_row(KIND_CLASSIFY, 0,    0, 1, 0, 0);
    add_row(KIND_REMOVE,   0,    0, 1, 0, 0);
    add_row(KIND_UNUSED,   1023, 7, 1, 0, 0);
    add_row(KIND_LEARN,    1023, 7, 1, 0, 1);
    add_row(KIND_CLASSIFY, 0,    5, 1, 0, 1);
    add_row(KIND_LEARN,    0,    0, 1, 0, 2);
    add_row(KIND_CLASSIFY, 1023, 0, 1, 1, 2);
    add_row(KIND_CLASSIFY, 0,    7, 1, 0, 2);
    add_row(KIND_CLASSIFY, 512,  3, 0, 0, 0);
    add_row(KIND_CLASSIFY, 511,  4, 0, 0, 0);
    add_row(KIND_REMOVE,   0,    5, 1, 0, 2);
    add_row(KIND_REMOVE,   0,    0, 1, 0, 1);
    add_row(KIND_LEARN,    100,  2, 0, 0, 0);
    add_row(KIND_LEARN,    200,  6, 0, 0, 0);
    add_row(KIND_CLASSIFY, 150,  1, 0, 0, 0);
    add_row(KIND_LEARN,    200,  0, 0, 0, 0);
    add_row(KIND_LEARN,    1023, 0, 0, 0, 0);
    add_row(KIND_LEARN,    555,  0, 0, 0, 0);
    add_row(KIND_LEARN,    1,    0, 0, 0, 0);
    add_row(KIND_LEARN,    1000, 0, 0, 0, 0);
    add_row(KIND_LEARN,    300,  0, 1, 0, 8);
    add_row(KIND_CLASSIFY, 1023, 7, 1, 7, 8);
    add_row(KIND_CLASSIFY, 0,    0, 1, 0, 8);
    add_row(KIND_REMOVE,   682,  7, 1, 0, 7);
    add_row(KIND_UNUSED,   0,    0, 1, 0, 7);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].stim, plan[i].known, plan[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) phase <= tb_phase_e'(PH_FREE + n / PHASE_LEN);
      send_item(make_item(), 1'b0, '0);
    end
    item_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0)
      $display("PASS learned_level_switch_decoder");
    else
      $display("FAIL learned_level_switch_decoder");
    $finish;
  end

endmodule
